/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL; clock clk, reset rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/sspq_pkg.sv */
// ----------------------------------------------------------------------------
// sspq_pkg
// Types and constants of the stable sorted priority queue.
// ----------------------------------------------------------------------------
package sspq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int DATA_W       = 16;
  localparam int PRIO_W       = 8;
  localparam int STATUS_W     = 2;
  localparam int OCC_W        = 5;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic              ins;
    logic              rem;
    logic [DATA_W-1:0] data;
    logic [PRIO_W-1:0] prio;
  } upd_t;

endpackage

/* hw/rtl/sspq_slot.sv */
// ----------------------------------------------------------------------------
// sspq_slot
// One slot of the sorted list: compares against the new priority and
// keeps, takes the new entry, or shifts from a neighbor.
// ----------------------------------------------------------------------------
module sspq_slot (
  input  logic                      clk,
  input  sspq_pkg::upd_t            upd,
  input  logic                      occupied,
  input  logic                      le_prev,
  input  logic [sspq_pkg::DATA_W-1:0] left_data,
  input  logic [sspq_pkg::PRIO_W-1:0] left_prio,
  input  logic [sspq_pkg::DATA_W-1:0] right_data,
  input  logic [sspq_pkg::PRIO_W-1:0] right_prio,
  output logic                      le,
  output logic [sspq_pkg::DATA_W-1:0] data_o,
  output logic [sspq_pkg::PRIO_W-1:0] prio_o
);
  import sspq_pkg::*;

  logic [DATA_W-1:0] data_r;
  logic [PRIO_W-1:0] prio_r;
  logic [DATA_W-1:0] data_nxt;
  logic [PRIO_W-1:0] prio_nxt;

  assign le     = occupied && (prio_r <= upd.prio);
  assign data_o = data_r;
  assign prio_o = prio_r;

  always_comb begin
    data_nxt = data_r;
    prio_nxt = prio_r;
    if (upd.ins) begin
      if (!le) begin
        if (le_prev) begin
          data_nxt = upd.data;
          prio_nxt = upd.prio;
        end else begin
          data_nxt = left_data;
          prio_nxt = left_prio;
        end
      end
    end else if (upd.rem) begin
      data_nxt = right_data;
      prio_nxt = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    prio_r <= prio_nxt;
  end

endmodule

/* hw/rtl/stable_sorted_priority_queue.sv */
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue
// Bounded priority queue kept sorted, lowest priority number first, equal
// priorities in arrival order.
// ----------------------------------------------------------------------------
// Each beat is an insert (data, priority) or a remove of the head, and gives
// exactly one result beat: status, removed data and occupancy. A beat is
// registered, then once the result register is free or being read, every
// slot compares its priority with the new one in parallel and the whole
// list shifts at once, writing the result register. One beat per cycle is
// sustained unless out_ready stalls. Inserts into a full queue are dropped
// with status full, removes from an empty queue report status empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stable_sorted_priority_queue #(
  parameter int CAPACITY = sspq_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_kind,
  input  logic [sspq_pkg::DATA_W-1:0]   in_item_data,
  input  logic [sspq_pkg::PRIO_W-1:0]   in_item_priority,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sspq_pkg::STATUS_W-1:0] out_status,
  output logic [sspq_pkg::DATA_W-1:0]   out_head_data,
  output logic [sspq_pkg::OCC_W-1:0]    out_occupancy
);
  import sspq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // input stage
  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_kind_r;
  logic [DATA_W-1:0] s1_data_r;
  logic [PRIO_W-1:0] s1_prio_r;
  logic              s1_adv;
  logic              in_acc;

  // queue state
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              full;
  logic              empty;
  upd_t              upd;

  // result stage
  logic                out_valid_r, out_valid_nxt;
  status_t             status_r, status_nxt;
  logic [DATA_W-1:0]   head_r, head_nxt;
  logic [OCC_W-1:0]    occ_r;

  logic [CAPACITY-1:0] le_w;
  logic [CAPACITY-1:0] occ_w;
  logic [DATA_W-1:0]   sdata [CAPACITY];
  logic [PRIO_W-1:0]   sprio [CAPACITY];

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  assign full  = (count_r == CNT_W'(CAPACITY));
  assign empty = (count_r == '0);

  assign upd.ins  = s1_adv && (s1_kind_r == KIND_INSERT) && !full;
  assign upd.rem  = s1_adv && (s1_kind_r == KIND_REMOVE) && !empty;
  assign upd.data = s1_data_r;
  assign upd.prio = s1_prio_r;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
    logic [DATA_W-1:0] ld, rd;
    logic [PRIO_W-1:0] lp, rp;
    logic              lep;
    assign occ_w[i] = (CNT_W'(i) < count_r);
    if (i == 0) begin : g_first
      assign ld  = s1_data_r;
      assign lp  = s1_prio_r;
      assign lep = 1'b1;
    end else begin : g_mid
      assign ld  = sdata[i-1];
      assign lp  = sprio[i-1];
      assign lep = le_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rd = sdata[i];
      assign rp = sprio[i];
    end else begin : g_inner
      assign rd = sdata[i+1];
      assign rp = sprio[i+1];
    end
    sspq_slot u_slot (
      .clk        (clk),
      .upd        (upd),
      .occupied   (occ_w[i]),
      .le_prev    (lep),
      .left_data  (ld),
      .left_prio  (lp),
      .right_data (rd),
      .right_prio (rp),
      .le         (le_w[i]),
      .data_o     (sdata[i]),
      .prio_o     (sprio[i])
    );
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (upd.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (upd.rem) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    head_nxt = '0;
    if (s1_kind_r == KIND_INSERT) begin
      status_nxt = full ? ST_FULL : ST_INSERTED;
    end else begin
      status_nxt = empty ? ST_EMPTY : ST_REMOVED;
      if (!empty) begin
        head_nxt = sdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r <= in_kind;
      s1_data_r <= in_item_data;
      s1_prio_r <= in_item_priority;
    end
    if (s1_adv) begin
      status_r <= status_nxt;
      head_r   <= head_nxt;
      occ_r    <= OCC_W'(count_nxt);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_head_data = head_r;
  assign out_occupancy = occ_r;

  `ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CNT_W'(CAPACITY))
  `ASSERT_IMPL(a_single_op, 1'b1, !(upd.ins && upd.rem))
  `ASSERT_IMPL(a_head_zero, out_valid_r && (status_r != ST_REMOVED), head_r == '0)
  `ASSERT_NEXT(a_rem_dec, upd.rem, count_r == $past(count_r) - CNT_W'(1))
  `ASSERT_NEXT(a_stall_hold, out_valid_r && !out_ready, out_valid_r && $stable(status_r))

endmodule

/* sim/sspq_result_checker.sv */
// ----------------------------------------------------------------------------
// sspq_result_checker
// Watches both channels of the sorted priority queue, predicts every result
// beat from its own copy of the sorted list and compares field by field.
// ----------------------------------------------------------------------------
module sspq_result_checker #(
  parameter int CAPACITY = sspq_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          in_kind,
  input  logic [sspq_pkg::DATA_W-1:0]   in_item_data,
  input  logic [sspq_pkg::PRIO_W-1:0]   in_item_priority,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [sspq_pkg::STATUS_W-1:0] out_status,
  input  logic [sspq_pkg::DATA_W-1:0]   out_head_data,
  input  logic [sspq_pkg::OCC_W-1:0]    out_occupancy,
  output int                            mismatches,
  output int                            pending,
  output int                            n_inserted,
  output int                            n_removed,
  output int                            n_empty,
  output int                            n_full
);
  timeunit 1ns;
  timeprecision 1ps;

  import sspq_pkg::*;

  typedef struct {
    status_t           status;
    logic [DATA_W-1:0] data;
    logic [OCC_W-1:0]  occ;
  } queue_result_t;

  logic [DATA_W-1:0] held_data [CAPACITY];
  logic [PRIO_W-1:0] held_prio [CAPACITY];
  int                held_count = 0;
  queue_result_t     expected_results [$];
  int                err_cnt = 0;
  int                ins_cnt = 0;
  int                rem_cnt = 0;
  int                empty_cnt = 0;
  int                full_cnt = 0;

  initial begin
    mismatches = 0;
    pending    = 0;
    n_inserted = 0;
    n_removed  = 0;
    n_empty    = 0;
    n_full     = 0;
  end

  // New entry lands after every held entry of lower or equal priority number.
  function automatic queue_result_t apply_queue_op(input logic kind,
                                                   input logic [DATA_W-1:0] d,
                                                   input logic [PRIO_W-1:0] p);
    queue_result_t r;
    int            pos;
    r.data = '0;
    if (kind == KIND_INSERT) begin
      if (held_count >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        pos = 0;
        for (int i = 0; i < held_count; i++) begin
          if (held_prio[i] <= p) pos = i + 1;
        end
        for (int i = held_count; i > pos; i--) begin
          held_data[i] = held_data[i-1];
          held_prio[i] = held_prio[i-1];
        end
        held_data[pos] = d;
        held_prio[pos] = p;
        held_count++;
        r.status = ST_INSERTED;
      end
    end else if (held_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.data = held_data[0];
      for (int i = 1; i < held_count; i++) begin
        held_data[i-1] = held_data[i];
        held_prio[i-1] = held_prio[i];
      end
      held_count--;
      r.status = ST_REMOVED;
    end
    r.occ = OCC_W'(held_count);
    return r;
  endfunction

  always @(posedge clk) begin
    queue_result_t want;
    if (!rst_n) begin
      held_count = 0;
      expected_results.delete();
    end else begin
      if (in_valid && in_ready) begin
        want = apply_queue_op(in_kind, in_item_data, in_item_priority);
        expected_results.push_back(want);
        case (want.status)
          ST_INSERTED: ins_cnt++;
          ST_REMOVED:  rem_cnt++;
          ST_EMPTY:    empty_cnt++;
          default:     full_cnt++;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result beat: status %0d data %h occupancy %0d",
                   $time, out_status, out_head_data, out_occupancy);
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status) begin
            err_cnt++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, out_status);
          end
          if (out_head_data !== want.data) begin
            err_cnt++;
            $display("%0t: head_data mismatch: expected %h, actual %h",
                     $time, want.data, out_head_data);
          end
          if (out_occupancy !== want.occ) begin
            err_cnt++;
            $display("%0t: occupancy mismatch: expected %0d, actual %0d",
                     $time, want.occ, out_occupancy);
          end
        end
      end
    end
    mismatches <= err_cnt;
    pending    <= expected_results.size();
    n_inserted <= ins_cnt;
    n_removed  <= rem_cnt;
    n_empty    <= empty_cnt;
    n_full     <= full_cnt;
  end

endmodule

/* sim/stable_sorted_priority_queue_test.sv */
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_test
// Drives insert and remove beats into the sorted priority queue under
// varying handshake idling and backpressure; a checker module predicts and
// compares every result beat.
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sspq_pkg::*;

  localparam int CAPACITY       = CAPACITY_DEF;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS    = 567;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_kind = KIND_INSERT;
  logic [DATA_W-1:0]   in_item_data = '0;
  logic [PRIO_W-1:0]   in_item_priority = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [DATA_W-1:0]   out_head_data;
  logic [OCC_W-1:0]    out_occupancy;

  int mismatches, pending, n_inserted, n_removed, n_empty, n_full;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_req = 0;
  int hold_done = 0;
  int hold_left = 0;
  int cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  stable_sorted_priority_queue #(.CAPACITY(CAPACITY)) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_item_data     (in_item_data),
    .in_item_priority (in_item_priority),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_head_data    (out_head_data),
    .out_occupancy    (out_occupancy)
  );

  sspq_result_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_item_data     (in_item_data),
    .in_item_priority (in_item_priority),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_head_data    (out_head_data),
    .out_occupancy    (out_occupancy),
    .mismatches       (mismatches),
    .pending          (pending),
    .n_inserted       (n_inserted),
    .n_removed        (n_removed),
    .n_empty          (n_empty),
    .n_full           (n_full)
  );

  // Result side: random stalls, or a long hold when one is requested.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_req != hold_done) begin
      hold_done <= hold_req;
      hold_left <= RX_HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("stable_sorted_priority_queue_test NOT OK");
      $finish;
    end
  end

  task automatic offer_beat(input logic kind, input logic [DATA_W-1:0] d,
                            input logic [PRIO_W-1:0] p);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= kind;
    in_item_data     <= d;
    in_item_priority <= p;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Half the picks are small values 0 to 3 and a fifth are 0 or 255, so ties are common.
  function automatic logic [PRIO_W-1:0] pick_priority();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return PRIO_W'($urandom_range(0, 3));
    if (r < 70) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    return PRIO_W'($urandom);
  endfunction

  // Runs of fill-heavy, drain-heavy and balanced traffic.
  task automatic run_random(input int n_items);
    int   left, seg, mode, ins_pct;
    logic kind;
    left = n_items;
    while (left > 0) begin
      mode    = $urandom_range(0, 2);
      ins_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
      seg     = $urandom_range(10, 40);
      if (seg > left) seg = left;
      repeat (seg) begin
        kind = ($urandom_range(0, 99) < ins_pct) ? KIND_INSERT : KIND_REMOVE;
        offer_beat(kind, DATA_W'($urandom), pick_priority());
      end
      left -= seg;
    end
  endtask

  localparam logic [PRIO_W-1:0] DIR_PRIO [16] = '{
    8'd255, 8'd0, 8'd7, 8'd7, 8'd0, 8'd255, 8'd128, 8'd7,
    8'd1, 8'd254, 8'd0, 8'd7, 8'd3, 8'd3, 8'd255, 8'd0
  };

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty remove, fill to capacity with ties and extremes, refused insert
    offer_beat(KIND_REMOVE, 16'hFFFF, 8'hFF);
    for (int i = 0; i < 16; i++) begin
      offer_beat(KIND_INSERT, (i == 0) ? 16'h0000 : (i == 5) ? 16'hFFFF : DATA_W'(i * 16'h1111 + i),
                 DIR_PRIO[i]);
    end
    offer_beat(KIND_INSERT, 16'hFFFF, 8'h00);
    repeat (7) offer_beat(KIND_REMOVE, 16'h0000, 8'h00);
    wait_drained();

    tx_idle_pct = 11;
    rx_idle_pct <= 56;
    run_random(PHASE_ITEMS);
    wait_drained();

    tx_idle_pct = 56;
    rx_idle_pct <= 11;
    run_random(PHASE_ITEMS);
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    hold_req <= hold_req + 1;
    run_random(PHASE_ITEMS);
    wait_drained();

    $display("Run covered %0d beats: %0d inserts, %0d removes with data,",
             n_inserted + n_removed + n_empty + n_full, n_inserted, n_removed);
    $display("%0d removes on an empty queue, %0d inserts refused when full, one long stall.",
             n_empty, n_full);
    if (mismatches == 0 && pending == 0) begin
      $display("stable_sorted_priority_queue_test OK");
    end else begin
      $display("stable_sorted_priority_queue_test NOT OK");
    end
    $finish;
  end

endmodule
